/* rtl/tcd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcd_pkg
// Shared constants, codes and controller/datapath interface types for the
// connection lookup block.
// ---------------------------------------------------------------------------
package tcd_pkg;

    // default number of connection slots
    localparam int TABLE_ENTRIES_DEF = 16;

    // field widths fixed by the interface
    localparam int SLOT_W    = 4;
    localparam int STATE_W   = 2;
    localparam int IP_W      = 32;
    localparam int PORT_W    = 16;
    localparam int MAC_W     = 48;
    localparam int LEN_W     = 16;
    localparam int HWORDS_W  = 4;
    localparam int VERDICT_W = 3;

    // width of one stored slot word: local ip, local port, remote ip, remote port
    localparam int ENTRY_W = 2 * IP_W + 2 * PORT_W;

    // slot state codes
    localparam logic [STATE_W-1:0] SLOT_FREE   = 2'd0;
    localparam logic [STATE_W-1:0] SLOT_LISTEN = 2'd1;

    // function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // verdict codes
    localparam logic [VERDICT_W-1:0] V_WRITTEN    = 3'd0;
    localparam logic [VERDICT_W-1:0] V_DROP_CAST  = 3'd1;
    localparam logic [VERDICT_W-1:0] V_DROP_SHORT = 3'd2;
    localparam logic [VERDICT_W-1:0] V_NO_MATCH   = 3'd3;
    localparam logic [VERDICT_W-1:0] V_EXACT      = 3'd4;
    localparam logic [VERDICT_W-1:0] V_LISTENER   = 3'd5;

    // multicast class prefix and minimum ip header length
    localparam logic [3:0]       MCAST_PREFIX   = 4'hE;
    localparam logic [LEN_W:0]   IP_HDR_BYTES   = 17'd20;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch the incoming word
        logic table_write;  // write the latched slot into the table
        logic scan_start;   // clear scan counter and match flags
        logic scan_issue;   // read the slot at the scan counter
        logic emit;         // present the result for one cycle
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_write;     // latched word is a table write
        logic drop;         // latched segment fails the cast or length check
        logic scan_last;    // scan counter is on the last slot
    } dp_status_t;

endpackage

/* rtl/tcd_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcd_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module tcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tcd_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcd_datapath
// Input latch, slot table, drop checks, slot scan compare and result
// registers for the connection lookup block.
// ---------------------------------------------------------------------------
module tcd_datapath #(
    parameter int TABLE_ENTRIES = tcd_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcd_pkg::ctrl_cmd_t            cmd,
    output tcd_pkg::dp_status_t           status,
    input  logic                          func,
    input  logic [tcd_pkg::SLOT_W-1:0]    slot,
    input  logic [tcd_pkg::STATE_W-1:0]   slot_state,
    input  logic [tcd_pkg::IP_W-1:0]      local_ip,
    input  logic [tcd_pkg::PORT_W-1:0]    local_port,
    input  logic [tcd_pkg::IP_W-1:0]      remote_ip,
    input  logic [tcd_pkg::PORT_W-1:0]    remote_port,
    input  logic [tcd_pkg::MAC_W-1:0]     dest_mac,
    input  logic [tcd_pkg::LEN_W-1:0]     ip_total_length,
    input  logic [tcd_pkg::HWORDS_W-1:0]  tcp_header_words,
    output logic                          done,
    output logic [tcd_pkg::VERDICT_W-1:0] verdict,
    output logic [tcd_pkg::SLOT_W-1:0]    matched_slot
);

    // only slot indices that the slot field can reach are ever filled
    localparam int SLOT_SPAN = 1 << tcd_pkg::SLOT_W;
    localparam int SCAN_N    = (TABLE_ENTRIES < SLOT_SPAN) ? TABLE_ENTRIES : SLOT_SPAN;
    localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W     = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

    // latched word
    logic                          func_reg;
    logic [tcd_pkg::SLOT_W-1:0]    slot_reg;
    logic [tcd_pkg::STATE_W-1:0]   state_in_reg;
    logic [tcd_pkg::IP_W-1:0]      lip_reg;
    logic [tcd_pkg::PORT_W-1:0]    lport_reg;
    logic [tcd_pkg::IP_W-1:0]      rip_reg;
    logic [tcd_pkg::PORT_W-1:0]    rport_reg;
    logic [tcd_pkg::MAC_W-1:0]     mac_reg;
    logic [tcd_pkg::LEN_W-1:0]     len_reg;
    logic [tcd_pkg::HWORDS_W-1:0]  hwords_reg;

    // slot states, cleared at reset
    logic [tcd_pkg::STATE_W-1:0]   slot_state_reg [TABLE_ENTRIES];

    // scan pipeline
    logic [CNT_W-1:0]              cnt_reg;
    logic                          rd_valid_reg;
    logic [CNT_W-1:0]              rd_idx_reg;
    logic [tcd_pkg::STATE_W-1:0]   rd_state_reg;
    logic [tcd_pkg::ENTRY_W-1:0]   rd_entry;

    // match tracking
    logic                          have_exact_reg;
    logic                          have_listen_reg;
    logic [tcd_pkg::SLOT_W-1:0]    exact_idx_reg;
    logic [tcd_pkg::SLOT_W-1:0]    listen_idx_reg;

    // result registers
    logic                          done_reg;
    logic [tcd_pkg::VERDICT_W-1:0] verdict_reg;
    logic [tcd_pkg::SLOT_W-1:0]    matched_reg;
    logic [tcd_pkg::VERDICT_W-1:0] verdict_next;
    logic [tcd_pkg::SLOT_W-1:0]    matched_next;

    logic                          in_range;
    logic [IDX_W-1:0]              wr_addr;
    logic [IDX_W-1:0]              rd_addr;
    logic [tcd_pkg::ENTRY_W-1:0]   wr_entry;
    logic                          is_cast;
    logic                          is_short;
    logic [tcd_pkg::LEN_W:0]       min_len;
    logic [tcd_pkg::IP_W-1:0]      e_lip;
    logic [tcd_pkg::PORT_W-1:0]    e_lport;
    logic [tcd_pkg::IP_W-1:0]      e_rip;
    logic [tcd_pkg::PORT_W-1:0]    e_rport;
    logic                          hit_exact;
    logic                          hit_listen;

    // latch the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg     <= func;
            slot_reg     <= slot;
            state_in_reg <= slot_state;
            lip_reg      <= local_ip;
            lport_reg    <= local_port;
            rip_reg      <= remote_ip;
            rport_reg    <= remote_port;
            mac_reg      <= dest_mac;
            len_reg      <= ip_total_length;
            hwords_reg   <= tcp_header_words;
        end
    end

    // drop checks on the latched segment
    assign min_len  = tcd_pkg::IP_HDR_BYTES
                      + {{(tcd_pkg::LEN_W + 1 - tcd_pkg::HWORDS_W - 2){1'b0}}, hwords_reg, 2'b00};
    assign is_cast  = (&mac_reg) || (lip_reg[tcd_pkg::IP_W-1 -: 4] == tcd_pkg::MCAST_PREFIX);
    assign is_short = ({1'b0, len_reg} < min_len);

    assign status.is_write  = (func_reg == tcd_pkg::FUNC_WRITE);
    assign status.drop      = is_cast || is_short;
    assign status.scan_last = (cnt_reg == CNT_W'(SCAN_N - 1));

    // table write addressing
    assign in_range = (int'(slot_reg) < TABLE_ENTRIES);
    assign wr_addr  = IDX_W'(slot_reg);
    assign rd_addr  = IDX_W'(cnt_reg);
    assign wr_entry = {lip_reg, lport_reg, rip_reg, rport_reg};

    // address and port words of every slot
    tcd_ram #(
        .WIDTH (tcd_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.table_write && in_range),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    // slot state flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_state_reg[i] <= tcd_pkg::SLOT_FREE;
            end
        end
        else if (cmd.table_write && in_range)
        begin
            slot_state_reg[wr_addr] <= state_in_reg;
        end
    end

    // scan counter and read alignment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_issue;
            if (cmd.scan_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan_issue && !status.scan_last)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= cnt_reg;
        rd_state_reg <= slot_state_reg[rd_addr];
    end

    // compare the slot read in the previous cycle
    assign {e_lip, e_lport, e_rip, e_rport} = rd_entry;

    always_comb
    begin
        hit_exact  = 1'b0;
        hit_listen = 1'b0;
        unique case (rd_state_reg)
            tcd_pkg::SLOT_FREE:
            begin
                hit_exact  = 1'b0;
                hit_listen = 1'b0;
            end
            tcd_pkg::SLOT_LISTEN:
            begin
                hit_listen = (e_lport == lport_reg)
                             && (((e_lip == '0) && !have_listen_reg) || (e_lip == lip_reg));
            end
            default:
            begin
                hit_exact = (e_rip == rip_reg) && (e_lip == lip_reg)
                            && (e_rport == rport_reg) && (e_lport == lport_reg);
            end
        endcase
    end

    // match flags; the first exact hit ends the search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_exact_reg  <= 1'b0;
            have_listen_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            have_exact_reg  <= 1'b0;
            have_listen_reg <= 1'b0;
        end
        else if (rd_valid_reg && !have_exact_reg)
        begin
            if (hit_exact)
            begin
                have_exact_reg <= 1'b1;
            end
            if (hit_listen)
            begin
                have_listen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg && !have_exact_reg)
        begin
            if (hit_exact)
            begin
                exact_idx_reg <= tcd_pkg::SLOT_W'(rd_idx_reg);
            end
            if (hit_listen)
            begin
                listen_idx_reg <= tcd_pkg::SLOT_W'(rd_idx_reg);
            end
        end
    end

    // verdict selection
    always_comb
    begin
        verdict_next = tcd_pkg::V_NO_MATCH;
        matched_next = '0;
        if (status.is_write)
        begin
            verdict_next = tcd_pkg::V_WRITTEN;
        end
        else if (is_cast)
        begin
            verdict_next = tcd_pkg::V_DROP_CAST;
        end
        else if (is_short)
        begin
            verdict_next = tcd_pkg::V_DROP_SHORT;
        end
        else if (have_exact_reg)
        begin
            verdict_next = tcd_pkg::V_EXACT;
            matched_next = exact_idx_reg;
        end
        else if (have_listen_reg)
        begin
            verdict_next = tcd_pkg::V_LISTENER;
            matched_next = listen_idx_reg;
        end
    end

    // result word and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            verdict_reg <= verdict_next;
            matched_reg <= matched_next;
        end
    end

    assign done         = done_reg;
    assign verdict      = verdict_reg;
    assign matched_slot = matched_reg;

endmodule

/* rtl/tcd_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcd_ctrl
// Sequencer for the connection lookup block: accepts a word, then writes
// the table, drops the segment or scans every slot before the result.
// ---------------------------------------------------------------------------
module tcd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output tcd_pkg::ctrl_cmd_t  cmd,
    input  tcd_pkg::dp_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    busy_next   = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_write)
                begin
                    cmd.table_write = 1'b1;
                    state_next      = ST_EMIT;
                end
                else if (status.drop)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                busy_next  = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // state and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

/* rtl/tcp_connection_demux_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcp_connection_demux_top
// Connection slot table with exact and listener lookup of arriving segments.
//
// A word is taken at a rising edge where start is high and busy is low.
// func low writes one whole slot (state, addresses, ports); func high looks
// up a segment. Each word gives exactly one result: verdict and
// matched_slot, valid for the single cycle in which done is high. The
// receiver cannot stall, so the result must be taken in that cycle.
// A slot write or a dropped segment (broadcast, multicast, short) skips
// the scan; a full lookup scans min(TABLE_ENTRIES,16) slots, reading one
// slot a cycle from the single read port of the slot RAM. busy is high
// from the accepting edge until the done cycle; a new word may start in
// the done cycle.
// Reset marks every slot free; slot addresses and ports are not cleared
// and are only compared for slots that have been written.
// ---------------------------------------------------------------------------
module tcp_connection_demux_top #(
    parameter int TABLE_ENTRIES = tcd_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [tcd_pkg::SLOT_W-1:0]    slot,
    input  logic [tcd_pkg::STATE_W-1:0]   slot_state,
    input  logic [tcd_pkg::IP_W-1:0]      local_ip,
    input  logic [tcd_pkg::PORT_W-1:0]    local_port,
    input  logic [tcd_pkg::IP_W-1:0]      remote_ip,
    input  logic [tcd_pkg::PORT_W-1:0]    remote_port,
    input  logic [tcd_pkg::MAC_W-1:0]     dest_mac,
    input  logic [tcd_pkg::LEN_W-1:0]     ip_total_length,
    input  logic [tcd_pkg::HWORDS_W-1:0]  tcp_header_words,
    output logic                          done,
    output logic [tcd_pkg::VERDICT_W-1:0] verdict,
    output logic [tcd_pkg::SLOT_W-1:0]    matched_slot
);

    tcd_pkg::ctrl_cmd_t  cmd;
    tcd_pkg::dp_status_t status;

    // sequencer
    tcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    // table, checks and scan
    tcd_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .func             (func),
        .slot             (slot),
        .slot_state       (slot_state),
        .local_ip         (local_ip),
        .local_port       (local_port),
        .remote_ip        (remote_ip),
        .remote_port      (remote_port),
        .dest_mac         (dest_mac),
        .ip_total_length  (ip_total_length),
        .tcp_header_words (tcp_header_words),
        .done             (done),
        .verdict          (verdict),
        .matched_slot     (matched_slot)
    );

endmodule

/* tb/tcp_connection_demux_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcp_connection_demux_top_tb
// Self-checking bench for the connection slot table and segment lookup.
// A short table of directed words covers the drop rules, the length edge,
// exact and listener priority and the extreme field values. Random slot
// writes and lookups follow, mostly aimed at stored slots. Every result is
// checked against a fixed value or a table model, with random sender gaps.
// ---------------------------------------------------------------------------
module tcp_connection_demux_top_tb;

    import tcd_pkg::*;

    localparam int SLOTS = TABLE_ENTRIES_DEF;

    // active slot codes, both treated as a live connection
    localparam logic [STATE_W-1:0] SLOT_ACTIVE     = 2'd2;
    localparam logic [STATE_W-1:0] SLOT_ACTIVE_ALT = 2'd3;

    localparam logic [MAC_W-1:0] MAC_BROADCAST = '1;
    localparam logic [MAC_W-1:0] MAC_HOST      = 48'h0200_0000_0001;
    localparam logic [IP_W-1:0]  IP_A          = 32'h0A00_0001;
    localparam logic [IP_W-1:0]  IP_B          = 32'h0A00_0002;
    localparam logic [IP_W-1:0]  IP_ANY        = 32'h0000_0000;
    localparam logic [PORT_W-1:0] PORT_HTTP    = 16'd80;
    localparam logic [PORT_W-1:0] PORT_HTTPS   = 16'd443;

    // one word as presented on the input ports
    typedef struct packed {
        logic                  func;
        logic [SLOT_W-1:0]     slot;
        logic [STATE_W-1:0]    slot_state;
        logic [IP_W-1:0]       local_ip;
        logic [PORT_W-1:0]     local_port;
        logic [IP_W-1:0]       remote_ip;
        logic [PORT_W-1:0]     remote_port;
        logic [MAC_W-1:0]      dest_mac;
        logic [LEN_W-1:0]      ip_total_length;
        logic [HWORDS_W-1:0]   tcp_header_words;
    } demux_word_t;

    typedef struct packed {
        logic [VERDICT_W-1:0]  verdict;
        logic [SLOT_W-1:0]     slot;
    } demux_result_t;

    typedef struct {
        demux_word_t   w;
        bit            known;
        demux_result_t res;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  func;
    logic [SLOT_W-1:0]     slot;
    logic [STATE_W-1:0]    slot_state;
    logic [IP_W-1:0]       local_ip;
    logic [PORT_W-1:0]     local_port;
    logic [IP_W-1:0]       remote_ip;
    logic [PORT_W-1:0]     remote_port;
    logic [MAC_W-1:0]      dest_mac;
    logic [LEN_W-1:0]      ip_total_length;
    logic [HWORDS_W-1:0]   tcp_header_words;
    logic                  done;
    logic [VERDICT_W-1:0]  verdict;
    logic [SLOT_W-1:0]     matched_slot;

    // local copy of the slot table
    logic [STATE_W-1:0]    tbl_state  [SLOTS];
    logic [IP_W-1:0]       tbl_lip    [SLOTS];
    logic [PORT_W-1:0]     tbl_lport  [SLOTS];
    logic [IP_W-1:0]       tbl_rip    [SLOTS];
    logic [PORT_W-1:0]     tbl_rport  [SLOTS];
    bit                    tbl_filled [SLOTS];

    demux_result_t  verdicts_due [$];
    directed_row_t  directed_rows [$];
    demux_result_t  head;
    int             mismatch_count = 0;

    tcp_connection_demux_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .func             (func),
        .slot             (slot),
        .slot_state       (slot_state),
        .local_ip         (local_ip),
        .local_port       (local_port),
        .remote_ip        (remote_ip),
        .remote_port      (remote_port),
        .dest_mac         (dest_mac),
        .ip_total_length  (ip_total_length),
        .tcp_header_words (tcp_header_words),
        .done             (done),
        .verdict          (verdict),
        .matched_slot     (matched_slot)
    );

    always #4 clk = ~clk;

    // table update and lookup verdict for one accepted word
    function automatic demux_result_t apply_word(input demux_word_t w);
        demux_result_t r;
        bit            got_exact;
        bit            got_listen;
        logic [SLOT_W-1:0] listen_idx;
        r.verdict  = V_WRITTEN;
        r.slot     = '0;
        got_exact  = 1'b0;
        got_listen = 1'b0;
        listen_idx = '0;
        if (w.func == FUNC_WRITE)
        begin
            tbl_state[w.slot]  = w.slot_state;
            tbl_lip[w.slot]    = w.local_ip;
            tbl_lport[w.slot]  = w.local_port;
            tbl_rip[w.slot]    = w.remote_ip;
            tbl_rport[w.slot]  = w.remote_port;
            tbl_filled[w.slot] = 1'b1;
            return r;
        end
        if (w.dest_mac == MAC_BROADCAST || w.local_ip[IP_W-1 -: 4] == MCAST_PREFIX)
        begin
            r.verdict = V_DROP_CAST;
        end
        else if (int'(w.ip_total_length) <
                 int'(IP_HDR_BYTES) + 4 * int'(w.tcp_header_words))
        begin
            r.verdict = V_DROP_SHORT;
        end
        else
        begin
            // first exact connection wins; listeners: last specific, else first wildcard
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!got_exact && tbl_state[i] != SLOT_FREE)
                begin
                    if (tbl_state[i] == SLOT_LISTEN)
                    begin
                        if (tbl_lport[i] == w.local_port &&
                            (tbl_lip[i] == w.local_ip ||
                             (tbl_lip[i] == IP_ANY && !got_listen)))
                        begin
                            got_listen = 1'b1;
                            listen_idx = SLOT_W'(i);
                        end
                    end
                    else if (tbl_lip[i] == w.local_ip && tbl_lport[i] == w.local_port &&
                             tbl_rip[i] == w.remote_ip && tbl_rport[i] == w.remote_port)
                    begin
                        got_exact = 1'b1;
                        r.slot    = SLOT_W'(i);
                    end
                end
            end
            if (got_exact)
                r.verdict = V_EXACT;
            else if (got_listen)
            begin
                r.verdict = V_LISTENER;
                r.slot    = listen_idx;
            end
            else
                r.verdict = V_NO_MATCH;
        end
        return r;
    endfunction

    function automatic demux_word_t mk_write(input logic [SLOT_W-1:0] s,
                                             input logic [STATE_W-1:0] st,
                                             input logic [IP_W-1:0] lip,
                                             input logic [PORT_W-1:0] lport,
                                             input logic [IP_W-1:0] rip,
                                             input logic [PORT_W-1:0] rport);
        demux_word_t w;
        w             = '0;
        w.func        = FUNC_WRITE;
        w.slot        = s;
        w.slot_state  = st;
        w.local_ip    = lip;
        w.local_port  = lport;
        w.remote_ip   = rip;
        w.remote_port = rport;
        return w;
    endfunction

    function automatic demux_word_t mk_lookup(input logic [IP_W-1:0] lip,
                                              input logic [PORT_W-1:0] lport,
                                              input logic [IP_W-1:0] rip,
                                              input logic [PORT_W-1:0] rport,
                                              input logic [MAC_W-1:0] mac,
                                              input logic [LEN_W-1:0] len,
                                              input logic [HWORDS_W-1:0] hw);
        demux_word_t w;
        w                  = '0;
        w.func             = FUNC_LOOKUP;
        w.local_ip         = lip;
        w.local_port       = lport;
        w.remote_ip        = rip;
        w.remote_port      = rport;
        w.dest_mac         = mac;
        w.ip_total_length  = len;
        w.tcp_header_words = hw;
        return w;
    endfunction

    function automatic void add_known(input demux_word_t w, input logic [VERDICT_W-1:0] v,
                                      input logic [SLOT_W-1:0] s);
        directed_row_t row;
        row.w           = w;
        row.known       = 1'b1;
        row.res.verdict = v;
        row.res.slot    = s;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_predicted(input demux_word_t w);
        directed_row_t row;
        row.w     = w;
        row.known = 1'b0;
        row.res   = '0;
        directed_rows.push_back(row);
    endfunction

    // mostly a small address pool so that lookups hit stored slots
    function automatic logic [IP_W-1:0] pick_ip();
        case ($urandom_range(5))
            0: return IP_A;
            1: return IP_B;
            2: return 32'hC0A8_0101;
            3: return 32'hFFFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        case ($urandom_range(4))
            0: return PORT_HTTP;
            1: return PORT_HTTPS;
            2: return 16'hFFFF;
            default: return PORT_W'($urandom_range(65535));
        endcase
    endfunction

    // present one word and hold it until the block takes it
    task automatic send_word(input demux_word_t w, input bit known,
                             input demux_result_t known_res);
        demux_result_t r;
        @(negedge clk);
        start            <= 1'b1;
        func             <= w.func;
        slot             <= w.slot;
        slot_state       <= w.slot_state;
        local_ip         <= w.local_ip;
        local_port       <= w.local_port;
        remote_ip        <= w.remote_ip;
        remote_port      <= w.remote_port;
        dest_mac         <= w.dest_mac;
        ip_total_length  <= w.ip_total_length;
        tcp_header_words <= w.tcp_header_words;
        do
            @(posedge clk);
        while (busy);
        r = apply_word(w);
        if (known)
            r = known_res;
        verdicts_due.push_back(r);
    endtask

    // stop sending until every outstanding result has been seen
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected result: verdict %0d slot %0d",
                         $time, verdict, matched_slot);
                mismatch_count++;
            end
            else
            begin
                head = verdicts_due.pop_front();
                if (verdict !== head.verdict)
                begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, head.verdict, verdict);
                    mismatch_count++;
                end
                if (matched_slot !== head.slot)
                begin
                    $display("%0t: matched_slot expected %0d actual %0d",
                             $time, head.slot, matched_slot);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        demux_word_t   w;
        demux_result_t none;
        int            idle_pct [4];
        int            k;
        int            pick;
        int            min_len;
        idle_pct = '{0, 65, 0, 37};
        none     = '0;

        rst_n            = 1'b0;
        start            = 1'b0;
        func             = FUNC_WRITE;
        slot             = '0;
        slot_state       = SLOT_FREE;
        local_ip         = '0;
        local_port       = '0;
        remote_ip        = '0;
        remote_port      = '0;
        dest_mac         = '0;
        ip_total_length  = '0;
        tcp_header_words = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_state[i]  = SLOT_FREE;
            tbl_filled[i] = 1'b0;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words: drop rules, length edge, priorities, extremes
        add_known(mk_lookup(IP_A, PORT_HTTP, IP_B, 16'd1234, MAC_HOST, 16'd40, 4'd5),
                  V_NO_MATCH, 4'd0);
        add_known(mk_lookup(IP_A, PORT_HTTP, IP_B, 16'd1234, MAC_BROADCAST, 16'd40, 4'd5),
                  V_DROP_CAST, 4'd0);
        add_known(mk_lookup(32'hE000_0001, PORT_HTTP, IP_B, 16'd1234, MAC_HOST, 16'd40, 4'd5),
                  V_DROP_CAST, 4'd0);
        add_known(mk_lookup(32'hEFFF_FFFF, PORT_HTTP, IP_B, 16'd1234, MAC_HOST, 16'd0, 4'd15),
                  V_DROP_CAST, 4'd0);
        add_known(mk_lookup(IP_A, PORT_HTTP, IP_B, 16'd1234, MAC_HOST, 16'd19, 4'd0),
                  V_DROP_SHORT, 4'd0);
        add_known(mk_lookup(IP_A, PORT_HTTP, IP_B, 16'd1234, MAC_HOST, 16'd79, 4'd15),
                  V_DROP_SHORT, 4'd0);
        add_known(mk_lookup(IP_A, PORT_HTTP, IP_B, 16'd1234, MAC_HOST, 16'd80, 4'd15),
                  V_NO_MATCH, 4'd0);
        add_known(mk_lookup('0, '0, '0, '0, '0, 16'hFFFF, 4'd15), V_NO_MATCH, 4'd0);
        add_known(mk_write(4'd0, SLOT_LISTEN, IP_ANY, PORT_HTTP, '0, '0), V_WRITTEN, 4'd0);
        add_known(mk_write(4'd15, SLOT_ACTIVE, '1, '1, '1, '1), V_WRITTEN, 4'd0);
        add_known(mk_write(4'd3, SLOT_LISTEN, IP_A, PORT_HTTP, '0, '0), V_WRITTEN, 4'd0);
        add_known(mk_write(4'd9, SLOT_LISTEN, IP_A, PORT_HTTP, '0, '0), V_WRITTEN, 4'd0);
        add_known(mk_write(4'd5, SLOT_ACTIVE_ALT, IP_A, PORT_HTTP, IP_B, 16'd1234),
                  V_WRITTEN, 4'd0);
        // exact on the all-ones slot, exact before listener, last specific listener
        add_predicted(mk_lookup('1, '1, '1, '1, 48'hFFFF_FFFF_FFFE, 16'hFFFF, 4'd15));
        add_predicted(mk_lookup(IP_A, PORT_HTTP, IP_B, 16'd1234, MAC_HOST, 16'd40, 4'd5));
        add_predicted(mk_lookup(IP_A, PORT_HTTP, IP_B, 16'd999, MAC_HOST, 16'd40, 4'd5));
        // wildcard listeners: the first one wins
        add_predicted(mk_lookup(IP_B, PORT_HTTP, IP_A, 16'd2000, MAC_HOST, 16'd40, 4'd5));
        add_known(mk_write(4'd7, SLOT_LISTEN, IP_ANY, PORT_HTTP, '0, '0), V_WRITTEN, 4'd0);
        add_predicted(mk_lookup(IP_B, PORT_HTTP, IP_A, 16'd2000, MAC_HOST, 16'd40, 4'd5));
        add_known(mk_write(4'd0, SLOT_FREE, '0, '0, '0, '0), V_WRITTEN, 4'd0);
        add_predicted(mk_lookup(IP_B, PORT_HTTP, IP_A, 16'd2000, MAC_HOST, 16'd40, 4'd5));
        add_predicted(mk_lookup(IP_B, PORT_HTTPS, IP_A, 16'd5000, MAC_HOST, 16'd40, 4'd5));
        add_known(mk_write(4'd3, SLOT_ACTIVE, IP_B, PORT_HTTPS, IP_A, 16'd5000),
                  V_WRITTEN, 4'd0);
        add_predicted(mk_lookup(IP_B, PORT_HTTPS, IP_A, 16'd5000, MAC_HOST, 16'd40, 4'd5));

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].res);
        drain();

        // random words in phases of differing sender gaps
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int n = 0; n < 450; n++)
            begin
                // fill every field so that ignored ones toggle too
                w.func             = 1'($urandom_range(1));
                w.slot             = SLOT_W'($urandom_range(15));
                w.slot_state       = STATE_W'($urandom_range(3));
                w.local_ip         = $urandom;
                w.local_port       = PORT_W'($urandom_range(65535));
                w.remote_ip        = $urandom;
                w.remote_port      = PORT_W'($urandom_range(65535));
                w.dest_mac         = {16'($urandom_range(65535)), 32'($urandom)};
                w.ip_total_length  = LEN_W'($urandom_range(65535));
                w.tcp_header_words = HWORDS_W'($urandom_range(15));

                if ($urandom_range(99) < 30)
                begin
                    // slot write, listeners and connections favoured
                    w.func = FUNC_WRITE;
                    pick   = $urandom_range(9);
                    if (pick < 2)
                        w.slot_state = SLOT_FREE;
                    else if (pick < 6)
                        w.slot_state = SLOT_LISTEN;
                    else if (pick < 9)
                        w.slot_state = SLOT_ACTIVE;
                    else
                        w.slot_state = SLOT_ACTIVE_ALT;
                    w.local_ip = (w.slot_state == SLOT_LISTEN && $urandom_range(2) == 0)
                                 ? IP_ANY : pick_ip();
                    w.local_port  = pick_port();
                    w.remote_ip   = pick_ip();
                    w.remote_port = pick_port();
                end
                else
                begin
                    // segment lookup, mostly aimed at a stored slot
                    w.func = FUNC_LOOKUP;
                    k      = $urandom_range(SLOTS - 1);
                    if (tbl_filled[k] && $urandom_range(99) < 70)
                    begin
                        w.local_ip    = (tbl_lip[k] == IP_ANY) ? pick_ip() : tbl_lip[k];
                        w.local_port  = tbl_lport[k];
                        w.remote_ip   = tbl_rip[k];
                        w.remote_port = tbl_rport[k];
                        case ($urandom_range(9))
                            0: w.remote_ip   = pick_ip();
                            1: w.remote_port = pick_port();
                            2: w.local_ip    = pick_ip();
                            default: ;
                        endcase
                    end
                    else
                    begin
                        w.local_ip    = pick_ip();
                        w.local_port  = pick_port();
                        w.remote_ip   = pick_ip();
                        w.remote_port = pick_port();
                    end
                    if ($urandom_range(24) == 0)
                        w.local_ip[IP_W-1 -: 4] = MCAST_PREFIX;
                    if ($urandom_range(19) == 0)
                        w.dest_mac = MAC_BROADCAST;
                    min_len = int'(IP_HDR_BYTES) + 4 * int'(w.tcp_header_words);
                    case ($urandom_range(9))
                        0: w.ip_total_length = LEN_W'($urandom_range(min_len - 1));
                        1: w.ip_total_length = LEN_W'(min_len - 1);
                        2: w.ip_total_length = LEN_W'(min_len);
                        3: w.ip_total_length = LEN_W'($urandom_range(65535));
                        default: w.ip_total_length = LEN_W'($urandom_range(1500, min_len));
                    endcase
                end

                // sender gap of random length
                if (idle_pct[ph] != 0 && $urandom_range(99) < idle_pct[ph])
                begin
                    @(negedge clk);
                    start <= 1'b0;
                    repeat ($urandom_range(23)) @(negedge clk);
                end
                else if ($urandom_range(99) == 0)
                    drain();
                send_word(w, 1'b0, none);
            end
            drain();
        end

        // tail: catch anything the block emits late
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
rtl/tcd_pkg.sv
rtl/tcd_ram.sv
rtl/tcd_datapath.sv
rtl/tcd_ctrl.sv
rtl/tcp_connection_demux_top.sv
tb/tcp_connection_demux_top_tb.sv
